// ----- hdl/nlmt_pkg.sv -----
// Shared types and constants for the name-list token matcher.
package nlmt_pkg;

   localparam int unsigned MAX_NAME_BYTES = 32;
   localparam int unsigned TARGET_BYTES   = 32;
   localparam int unsigned TPOS_W         = 6;
   localparam int unsigned TIDX_W         = $clog2(TARGET_BYTES);
   localparam int unsigned LEN_W          = 32;
   localparam int unsigned CSR_DATA_W     = 64;
   localparam int unsigned CSR_INDEX_W    = 3;
   localparam int unsigned RSP_DATA_W     = 40;
   localparam logic [7:0]  COMMA_BYTE     = 8'h2C;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TARGET_LEN     = 3'd0,
      REG_TARGET_BYTES_A = 3'd1,
      REG_TARGET_BYTES_B = 3'd2,
      REG_TARGET_BYTES_C = 3'd3,
      REG_TARGET_BYTES_D = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [TPOS_W-1:0]         len;
      logic                      usable;
      logic [TARGET_BYTES*8-1:0] bytes;
   } target_type;

   typedef struct packed {
      logic             valid;
      logic             found;
      logic [LEN_W-1:0] list_length;
   } result_type;

endpackage

// ----- hdl/nlmt_cfg.sv -----
// Target name registers behind the configuration write channel.
module nlmt_cfg (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [nlmt_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [nlmt_pkg::CSR_DATA_W-1:0]       csr_data,
   output nlmt_pkg::target_type                  target
);

   logic [nlmt_pkg::TPOS_W-1:0]           len_ff, len_in;
   logic [nlmt_pkg::TARGET_BYTES*8-1:0]   bytes_ff, bytes_in;

   always_comb begin
      len_in   = len_ff;
      bytes_in = bytes_ff;
      if (csr_valid) begin
         unique case (nlmt_pkg::csr_index_type'(csr_index))
            nlmt_pkg::REG_TARGET_LEN:     len_in = csr_data[nlmt_pkg::TPOS_W-1:0];
            nlmt_pkg::REG_TARGET_BYTES_A: bytes_in[63:0]    = csr_data;
            nlmt_pkg::REG_TARGET_BYTES_B: bytes_in[127:64]  = csr_data;
            nlmt_pkg::REG_TARGET_BYTES_C: bytes_in[191:128] = csr_data;
            nlmt_pkg::REG_TARGET_BYTES_D: bytes_in[255:192] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= nlmt_pkg::TPOS_W'(1);
         bytes_ff <= '0;
      end else begin
         len_ff   <= len_in;
         bytes_ff <= bytes_in;
      end
   end

   assign target.len    = len_ff;
   assign target.usable = (len_ff != '0) &&
                          ({1'b0, len_ff} <= (nlmt_pkg::TPOS_W+1)'(nlmt_pkg::MAX_NAME_BYTES));
   assign target.bytes  = bytes_ff;

endmodule

// ----- hdl/nlmt_core.sv -----
// Per-byte list parser and token compare; state advances when a byte is processed.
module nlmt_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              stream_byte,
   input  nlmt_pkg::target_type    target,
   output nlmt_pkg::result_type    result
);

   localparam int unsigned TP = nlmt_pkg::TPOS_W;
   localparam int unsigned LW = nlmt_pkg::LEN_W;

   logic           in_body_ff, in_body_in;
   logic [1:0]     prefix_count_ff, prefix_count_in;
   logic [LW-1:0]  decl_len_ff, decl_len_in;
   logic [LW-1:0]  bytes_left_ff, bytes_left_in;
   logic [TP-1:0]  token_pos_ff, token_pos_in;
   logic           token_eq_ff, token_eq_in;
   logic           match_seen_ff, match_seen_in;

   logic [7:0]     tbyte;
   logic           tbyte_hit;

   // Target byte at the current token position; positions past the store read as zero.
   always_comb begin
      if (token_pos_ff >= TP'(nlmt_pkg::TARGET_BYTES)) begin
         tbyte = 8'h00;
      end else begin
         tbyte = target.bytes[token_pos_ff[nlmt_pkg::TIDX_W-1:0]*8 +: 8];
      end
      tbyte_hit = (token_pos_ff < target.len) && (stream_byte == tbyte);
   end

   always_comb begin
      logic [LW-1:0]  len_shift;
      logic [1:0]     pc_next;
      logic           match_a;
      logic [TP-1:0]  pos_a;
      logic           eq_a;

      len_shift = {decl_len_ff[LW-9:0], stream_byte};
      pc_next   = prefix_count_ff + 2'd1;
      match_a   = match_seen_ff;
      pos_a     = token_pos_ff;
      eq_a      = token_eq_ff;

      in_body_in      = in_body_ff;
      prefix_count_in = prefix_count_ff;
      decl_len_in     = decl_len_ff;
      bytes_left_in   = bytes_left_ff;
      token_pos_in    = token_pos_ff;
      token_eq_in     = token_eq_ff;
      match_seen_in   = match_seen_ff;
      result          = '0;

      if (!in_body_ff) begin
         decl_len_in     = len_shift;
         prefix_count_in = pc_next;
         if (pc_next == 2'd0) begin
            token_pos_in  = '0;
            token_eq_in   = 1'b1;
            match_seen_in = 1'b0;
            if (len_shift == '0) begin
               // empty list reports right after its length
               result.valid = 1'b1;
               decl_len_in  = '0;
            end else begin
               bytes_left_in = len_shift;
               in_body_in    = 1'b1;
            end
         end
      end else begin
         if (stream_byte == nlmt_pkg::COMMA_BYTE) begin
            match_a = match_seen_ff | (target.usable && token_eq_ff &&
                                       token_pos_ff == target.len);
            pos_a   = '0;
            eq_a    = 1'b1;
         end else if (tbyte_hit) begin
            pos_a = token_pos_ff + TP'(1);
         end else begin
            eq_a = 1'b0;
         end
         bytes_left_in = bytes_left_ff - LW'(1);
         token_pos_in  = pos_a;
         token_eq_in   = eq_a;
         match_seen_in = match_a;
         if (bytes_left_ff == LW'(1)) begin
            // last byte: close the final token and report
            result.valid       = 1'b1;
            result.found       = match_a | (target.usable && eq_a && pos_a == target.len);
            result.list_length = decl_len_ff;
            token_pos_in       = '0;
            token_eq_in        = 1'b1;
            in_body_in         = 1'b0;
            prefix_count_in    = 2'd0;
            decl_len_in        = '0;
            match_seen_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff      <= 1'b0;
         prefix_count_ff <= '0;
         decl_len_ff     <= '0;
         bytes_left_ff   <= '0;
         token_pos_ff    <= '0;
         token_eq_ff     <= 1'b1;
         match_seen_ff   <= 1'b0;
      end else if (step) begin
         in_body_ff      <= in_body_in;
         prefix_count_ff <= prefix_count_in;
         decl_len_ff     <= decl_len_in;
         bytes_left_ff   <= bytes_left_in;
         token_pos_ff    <= token_pos_in;
         token_eq_ff     <= token_eq_in;
         match_seen_ff   <= match_seen_in;
      end
   end

endmodule

// ----- hdl/name_list_token_matcher_top.sv -----
// Top level of the SSH name-list token matcher: input register, parser, result register.
//
//  channel  direction  handshake               payload
//  req      in         req_tvalid/req_tready   req_tdata[7:0] = stream_byte
//  rsp      out        rsp_tvalid/rsp_tready   rsp_tdata[0] = found, [32:1] = list_length
//  csr      in         csr_valid/csr_ready     csr_index (register), csr_data
//
// One byte per cycle sustained while the result side is not stalled; a byte is parsed from the
// input register and its result is loaded into the result register when the parser advances.
// Reset is synchronous: parser state returns to expecting a length, target to length 1.
// A stalled result holds the parser; the input register takes at most one more byte,
// then req_tready stays low until the result is taken. csr_ready is always high.
module name_list_token_matcher_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [7:0]                             req_tdata,   // [7:0] stream_byte
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [nlmt_pkg::RSP_DATA_W-1:0]        rsp_tdata,   // [0] found, [32:1] list_length
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [nlmt_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [nlmt_pkg::CSR_DATA_W-1:0]        csr_data
);

   nlmt_pkg::target_type  target;
   nlmt_pkg::result_type  result;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff, out_valid_in;
   logic        out_found_ff;
   logic [nlmt_pkg::LEN_W-1:0] out_len_ff;
   logic        advance;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   nlmt_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .target    (target)
   );

   nlmt_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .stream_byte (in_byte_ff),
      .target      (target),
      .result      (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff && !rsp_tready;
      if (advance && result.valid) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      if (advance && result.valid) begin
         out_found_ff <= result.found;
         out_len_ff   <= result.list_length;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(nlmt_pkg::RSP_DATA_W - nlmt_pkg::LEN_W - 1)'(0), out_len_ff,
                        out_found_ff};

endmodule

// ----- tb/name_list_token_matcher_top_test.sv -----
// Self-checking testbench for the name-list token matcher: directed lists, back-pressure, random lists.
module name_list_token_matcher_top_test;

   localparam int MAX_IDLE         = 18;
   localparam int SETTLE_CYCLES    = 8;
   localparam int WATCHDOG_CYCLES  = 2000;
   localparam int RSP_HOLD_CYCLES  = 300;
   localparam int RANDOM_PHASES    = 8;
   localparam int ITEMS_PER_PHASE  = 10;
   localparam int FILL_LISTS       = 12;
   localparam int REG_FIRST_UNUSED = int'(nlmt_pkg::REG_TARGET_BYTES_D) + 1;

   typedef struct packed {
      logic                       found;
      logic [nlmt_pkg::LEN_W-1:0] list_length;
   } list_verdict_type;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [7:0]                       req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [nlmt_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [nlmt_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [nlmt_pkg::CSR_DATA_W-1:0]  csr_data;

   // local copy of the target and of the parser state
   logic [nlmt_pkg::TPOS_W-1:0]         tgt_len;
   logic [nlmt_pkg::TARGET_BYTES*8-1:0] tgt_flat;
   logic                                in_body;
   logic [1:0]                          prefix_cnt;
   logic [nlmt_pkg::LEN_W-1:0]          declared_len;
   logic [nlmt_pkg::LEN_W-1:0]          body_left;
   logic [nlmt_pkg::TPOS_W-1:0]         tok_pos;
   logic                                tok_equal;
   logic                                list_hit;

   list_verdict_type expected_lists[$];
   list_verdict_type want;
   logic [7:0]       list_body[$];

   int req_max_gap     = MAX_IDLE;
   int rsp_max_stall   = MAX_IDLE;
   int rsp_hold_cycles = 0;
   int bytes_sent      = 0;
   int mismatches      = 0;
   int idle_cycles     = 0;

   name_list_token_matcher_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   function automatic logic [7:0] target_byte_at(input int pos);
      return (pos >= nlmt_pkg::TARGET_BYTES) ? 8'h00 : tgt_flat[pos*8 +: 8];
   endfunction

   function automatic void end_token();
      if (tgt_len != 0 && tgt_len <= nlmt_pkg::MAX_NAME_BYTES && tok_equal &&
          tok_pos == tgt_len) begin
         list_hit = 1'b1;
      end
      tok_pos   = '0;
      tok_equal = 1'b1;
   endfunction

   function automatic void predict_list_byte(input logic [7:0] b);
      if (!in_body) begin
         declared_len = {declared_len[nlmt_pkg::LEN_W-9:0], b};
         prefix_cnt   = prefix_cnt + 2'd1;
         if (prefix_cnt == 2'd0) begin
            tok_pos   = '0;
            tok_equal = 1'b1;
            list_hit  = 1'b0;
            if (declared_len == 0) begin
               // empty list reports on its last length byte
               expected_lists.push_back('{found: 1'b0, list_length: '0});
            end else begin
               body_left = declared_len;
               in_body   = 1'b1;
            end
         end
      end else begin
         if (b == nlmt_pkg::COMMA_BYTE) begin
            end_token();
         end else if (tok_pos < tgt_len && b == target_byte_at(tok_pos)) begin
            tok_pos = tok_pos + 1'b1;
         end else begin
            tok_equal = 1'b0;
         end
         body_left = body_left - (nlmt_pkg::LEN_W)'(1);
         if (body_left == 0) begin
            end_token();
            expected_lists.push_back('{found: list_hit, list_length: declared_len});
            in_body      = 1'b0;
            prefix_cnt   = '0;
            declared_len = '0;
            list_hit     = 1'b0;
         end
      end
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = $urandom_range(0, req_max_gap);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = b;
      do @(posedge clock); while (!req_tready);
      predict_list_byte(b);
      bytes_sent++;
   endtask

   task automatic send_list();
      logic [nlmt_pkg::LEN_W-1:0] n;
      n = list_body.size();
      for (int k = 3; k >= 0; k--) send_byte(n[k*8 +: 8]);
      foreach (list_body[k]) send_byte(list_body[k]);
   endtask

   task automatic send_text_list(input string s);
      list_body.delete();
      for (int i = 0; i < s.len(); i++) list_body.push_back(s[i]);
      send_list();
   endtask

   task automatic write_csr(input logic [nlmt_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [nlmt_pkg::CSR_DATA_W-1:0]  data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         nlmt_pkg::REG_TARGET_LEN:     tgt_len = data[nlmt_pkg::TPOS_W-1:0];
         nlmt_pkg::REG_TARGET_BYTES_A: tgt_flat[63:0]    = data;
         nlmt_pkg::REG_TARGET_BYTES_B: tgt_flat[127:64]  = data;
         nlmt_pkg::REG_TARGET_BYTES_C: tgt_flat[191:128] = data;
         nlmt_pkg::REG_TARGET_BYTES_D: tgt_flat[255:192] = data;
         default: ;  // unused index, no effect
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // sender pause: every expected list result has come back and the pipe is empty
   task automatic wait_lists_done();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (expected_lists.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_target(input int len,
                              input logic [nlmt_pkg::TARGET_BYTES*8-1:0] bytes);
      logic [nlmt_pkg::CSR_DATA_W-1:0] len_word;
      wait_lists_done();
      len_word = {$urandom, $urandom};
      len_word[nlmt_pkg::TPOS_W-1:0] = (nlmt_pkg::TPOS_W)'(len);
      write_csr(nlmt_pkg::REG_TARGET_LEN, len_word);
      write_csr(nlmt_pkg::REG_TARGET_BYTES_A, bytes[63:0]);
      write_csr(nlmt_pkg::REG_TARGET_BYTES_B, bytes[127:64]);
      write_csr(nlmt_pkg::REG_TARGET_BYTES_C, bytes[191:128]);
      write_csr(nlmt_pkg::REG_TARGET_BYTES_D, bytes[255:192]);
   endtask

   // ---------------------------------------------------------------- random content

   // small alphabet so tokens collide with the target often
   function automatic logic [7:0] pick_name_byte();
      int         r;
      logic [7:0] v;
      r = $urandom_range(0, 15);
      if (r < 12)       v = 8'h61 + 8'($urandom_range(0, 3));
      else if (r == 12) v = 8'h00;
      else if (r == 13) v = 8'hFF;
      else              v = 8'($urandom_range(0, 255));
      return v;
   endfunction

   function automatic logic [nlmt_pkg::TARGET_BYTES*8-1:0] random_target_bytes();
      logic [nlmt_pkg::TARGET_BYTES*8-1:0] v;
      for (int i = 0; i < nlmt_pkg::TARGET_BYTES; i++) v[i*8 +: 8] = pick_name_byte();
      return v;
   endfunction

   task automatic build_name_list();
      int ntok, kind, n, cut;
      list_body.delete();
      ntok = $urandom_range(1, 4);
      if ($urandom_range(0, 7) == 0) list_body.push_back(nlmt_pkg::COMMA_BYTE);
      for (int t = 0; t < ntok; t++) begin
         if (t > 0) list_body.push_back(nlmt_pkg::COMMA_BYTE);
         kind = $urandom_range(0, 9);
         // 0-2 exact, 3 short prefix, 4 one byte too long, 5 one byte changed, 6 empty, 7-9 random bytes
         if (kind <= 5) begin
            n   = (kind == 3 && tgt_len > 0) ? $urandom_range(0, tgt_len - 1) : tgt_len;
            cut = (kind == 5 && n > 0) ? $urandom_range(0, n - 1) : -1;
            for (int i = 0; i < n; i++) begin
               list_body.push_back(i == cut ? pick_name_byte() : target_byte_at(i));
            end
            if (kind == 4) list_body.push_back(pick_name_byte());
         end else if (kind >= 7) begin
            n = $urandom_range(1, 6);
            repeat (n) list_body.push_back(pick_name_byte());
         end
      end
      if ($urandom_range(0, 7) == 0) list_body.push_back(nlmt_pkg::COMMA_BYTE);
   endtask

   task automatic build_noise_list();
      list_body.delete();
      repeat ($urandom_range(1, 12)) list_body.push_back(8'($urandom_range(0, 255)));
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_after_reset();
      // target is a single zero byte out of reset
      list_body.delete();
      list_body.push_back(8'h00);
      send_list();
   endtask

   task automatic test_token_rules();
      logic [nlmt_pkg::TARGET_BYTES*8-1:0] ab;
      ab = '0;
      ab[15:0] = "ba";
      load_target(2, ab);
      list_body.delete();
      send_list();              // zero length
      send_text_list("ab");     // match on the final token
      send_text_list(",abc,");  // prefix only, empty tokens around it
      send_text_list("a");      // list shorter than the target
   endtask

   task automatic test_unknown_index();
      wait_lists_done();
      for (int i = REG_FIRST_UNUSED; i < 2**nlmt_pkg::CSR_INDEX_W; i++) begin
         write_csr((nlmt_pkg::CSR_INDEX_W)'(i), {$urandom, $urandom});
      end
      send_text_list("ab");
   endtask

   task automatic test_fill_and_stall();
      req_max_gap     = 0;
      rsp_hold_cycles = RSP_HOLD_CYCLES;
      repeat (FILL_LISTS) send_text_list("x,ab");
      req_max_gap = MAX_IDLE;
      wait_lists_done();
   endtask

   task automatic test_unusable_target();
      logic [nlmt_pkg::TARGET_BYTES*8-1:0] ab;
      ab = '0;
      ab[15:0] = "ba";
      load_target(0, ab);
      send_text_list(",");
      load_target(nlmt_pkg::MAX_NAME_BYTES + 1, ab);
      send_text_list("ab");
   endtask

   task automatic test_random_lists();
      int len, phase_start;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       len = 1;
            1:       len = nlmt_pkg::MAX_NAME_BYTES;
            2:       len = 0;
            3:       len = 2**nlmt_pkg::TPOS_W - 1;
            default: len = $urandom_range(1, nlmt_pkg::MAX_NAME_BYTES);
         endcase
         load_target(len, random_target_bytes());
         req_max_gap   = (phase % 3 == 2) ? 0 : MAX_IDLE;
         rsp_max_stall = (phase % 3 == 2) ? 0 : MAX_IDLE;
         if (phase == 4) begin
            // one list long enough to use the third length byte
            build_name_list();
            repeat ($urandom_range(256, 300)) list_body.push_front(pick_name_byte());
            send_list();
         end
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 7) == 0) build_noise_list();
            else build_name_list();
            send_list();
         end
      end
      req_max_gap   = MAX_IDLE;
      rsp_max_stall = MAX_IDLE;
   endtask

   // ---------------------------------------------------------------- result side

   initial begin : rsp_drive
      int stall;
      rsp_tready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = $urandom_range(0, rsp_max_stall);
         end
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready) && rsp_hold_cycles == 0);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_lists.size() == 0) begin
            $display("%0t: unexpected result found=%0d list_length=%0d", $time,
                     rsp_tdata[0], rsp_tdata[nlmt_pkg::LEN_W:1]);
            mismatches++;
         end else begin
            want = expected_lists.pop_front();
            if (rsp_tdata[0] !== want.found) begin
               $display("%0t: found expected %0d actual %0d", $time, want.found, rsp_tdata[0]);
               mismatches++;
            end
            if (rsp_tdata[nlmt_pkg::LEN_W:1] !== want.list_length) begin
               $display("%0t: list_length expected %0d actual %0d", $time,
                        want.list_length, rsp_tdata[nlmt_pkg::LEN_W:1]);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      tgt_len      = (nlmt_pkg::TPOS_W)'(1);
      tgt_flat     = '0;
      in_body      = 1'b0;
      prefix_cnt   = '0;
      declared_len = '0;
      body_left    = '0;
      tok_pos      = '0;
      tok_equal    = 1'b1;
      list_hit     = 1'b0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      test_after_reset();
      test_token_rules();
      test_unknown_index();
      test_fill_and_stall();
      test_unusable_target();
      test_random_lists();

      wait_lists_done();
      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
